FILE: rtl/core/eth_hp_pkg.sv
package eth_hp_pkg;

    // Header offsets and lengths in bytes, and other header constants
    localparam logic [7:0] ETH_HDR_LEN  = 8'd14;
    localparam logic [7:0] IP_HDR_END   = 8'd34;
    localparam logic [7:0] TCP_HDR_LEN  = 8'd20;
    localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
    localparam logic [7:0] COUNT_MAX    = 8'd255;
    localparam logic [3:0] IHL_MIN      = 4'd5;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT_ETH = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_SHORT_IP  = 3'd3,
        ST_BAD_IHL   = 3'd4,
        ST_BAD_TLEN  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2,
        L4_ICMP = 2'd3
    } l4_kind_t;

    // Captured header fields of the frame in progress
    typedef struct packed {
        logic [7:0]  byte_count;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [15:0] total_len;
        logic [7:0]  proto;
        logic        frag;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
    } frame_t;

    // One frame summary
    typedef struct packed {
        status_t     status;
        logic [15:0] ethertype;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic        ip_valid;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_length;
        l4_kind_t    l4_kind;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
    } summary_t;

    // Byte offset of the L4 header
    function automatic logic [7:0] l4_start(input logic [3:0] ihl);
        l4_start = ETH_HDR_LEN + {2'b00, ihl, 2'b00};
    endfunction

endpackage

FILE: rtl/core/eth_hp_capture.sv
module eth_hp_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output eth_hp_pkg::frame_t  upd
);
    import eth_hp_pkg::*;

    frame_t      frame_reg;
    frame_t      frame_next;
    logic [7:0]  idx;
    logic [7:0]  l4off;

    // Field capture for the byte at the current offset
    always_comb
    begin
        frame_next = frame_reg;
        idx        = frame_reg.byte_count;
        l4off      = l4_start(frame_reg.ihl);

        if (idx < 8'd6)
            frame_next.dst_mac = {frame_reg.dst_mac[39:0], data_byte};
        else if (idx < 8'd12)
            frame_next.src_mac = {frame_reg.src_mac[39:0], data_byte};
        else if (idx < 8'd14)
            frame_next.ethertype = {frame_reg.ethertype[7:0], data_byte};
        else if (idx == 8'd14)
            frame_next.ihl = data_byte[3:0];
        else if (idx == 8'd16 || idx == 8'd17)
            frame_next.total_len = {frame_reg.total_len[7:0], data_byte};
        else if (idx == 8'd20)
            frame_next.frag = (data_byte[5:0] != 6'd0);
        else if (idx == 8'd21)
            frame_next.frag = frame_reg.frag || (data_byte != 8'd0);
        else if (idx == 8'd23)
            frame_next.proto = data_byte;
        else if (idx >= 8'd26 && idx < 8'd30)
            frame_next.src_ip = {frame_reg.src_ip[23:0], data_byte};
        else if (idx >= 8'd30 && idx < 8'd34)
            frame_next.dst_ip = {frame_reg.dst_ip[23:0], data_byte};

        // L4 ports sit right after the IP header, options included
        if (frame_reg.ihl >= IHL_MIN && idx >= IP_HDR_END)
        begin
            if (idx == l4off || idx == l4off + 8'd1)
                frame_next.l4_sport = {frame_reg.l4_sport[7:0], data_byte};
            else if (idx == l4off + 8'd2 || idx == l4off + 8'd3)
                frame_next.l4_dport = {frame_reg.l4_dport[7:0], data_byte};
        end

        // Byte counter stops at its maximum
        if (frame_reg.byte_count != COUNT_MAX)
            frame_next.byte_count = frame_reg.byte_count + 8'd1;
    end

    assign upd = frame_next;

    // State clears after the last byte of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_reg <= '0;
        else if (advance)
            frame_reg <= last_byte ? '0 : frame_next;
    end

endmodule

FILE: rtl/core/eth_hp_summary.sv
module eth_hp_summary (
    input  eth_hp_pkg::frame_t    frame,
    output eth_hp_pkg::summary_t  summ
);
    import eth_hp_pkg::*;

    logic [7:0] len;
    logic [7:0] l4off;
    logic       eth_ok;
    logic       ip_ok;
    logic       ports;
    status_t    status;
    l4_kind_t   kind;

    // Status checks, in priority order
    always_comb
    begin
        len    = frame.byte_count;
        l4off  = l4_start(frame.ihl);
        eth_ok = 1'b0;
        ip_ok  = 1'b0;
        status = ST_OK;
        if (len < ETH_HDR_LEN)
            status = ST_SHORT_ETH;
        else
        begin
            eth_ok = 1'b1;
            if (frame.ethertype != ETYPE_IPV4)
                status = ST_NOT_IPV4;
            else if (len < IP_HDR_END)
                status = ST_SHORT_IP;
            else
            begin
                ip_ok = 1'b1;
                if (frame.ihl < IHL_MIN)
                    status = ST_BAD_IHL;
                else if (frame.total_len < {10'd0, frame.ihl, 2'b00})
                    status = ST_BAD_TLEN;
            end
        end
    end

    // L4 classification; TCP and UDP need an unfragmented, long enough frame
    always_comb
    begin
        kind  = L4_NONE;
        ports = 1'b0;
        if (ip_ok && status == ST_OK)
        begin
            case (frame.proto)
                PROTO_TCP:
                begin
                    if (!frame.frag && len >= l4off + TCP_HDR_LEN)
                    begin
                        kind  = L4_TCP;
                        ports = 1'b1;
                    end
                end
                PROTO_UDP:
                begin
                    if (!frame.frag && len >= l4off + UDP_HDR_LEN)
                    begin
                        kind  = L4_UDP;
                        ports = 1'b1;
                    end
                end
                PROTO_ICMP:
                    kind = L4_ICMP;
                default:
                    kind = L4_NONE;
            endcase
        end
    end

    // Mask fields that the status says are not present
    always_comb
    begin
        summ.status      = status;
        summ.ethertype   = eth_ok ? frame.ethertype : 16'd0;
        summ.dst_mac     = eth_ok ? frame.dst_mac : 48'd0;
        summ.src_mac     = eth_ok ? frame.src_mac : 48'd0;
        summ.ip_valid    = ip_ok;
        summ.src_ip      = ip_ok ? frame.src_ip : 32'd0;
        summ.dst_ip      = ip_ok ? frame.dst_ip : 32'd0;
        summ.ip_protocol = ip_ok ? frame.proto : 8'd0;
        summ.ip_length   = ip_ok ? frame.total_len : 16'd0;
        summ.l4_kind     = kind;
        summ.l4_sport    = ports ? frame.l4_sport : 16'd0;
        summ.l4_dport    = ports ? frame.l4_dport : 16'd0;
    end

endmodule

FILE: rtl/core/eth_ipv4_l4_header_parser.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  data_byte, last_byte
// out      output     out_valid / out_ready status .. l4_dport (one summary per frame)
//
// One byte item is taken every cycle unless a last byte is held; the byte passes an input register, then
// the capture logic, and the last byte of a frame loads the result register.
// Reset clears the input stage, the captured header state and out_valid.
// While a summary waits on out_ready, non-last bytes keep flowing; only a
// last byte waiting in the input register holds off further items.
module eth_ipv4_l4_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] ethertype,
    output logic [47:0] dst_mac,
    output logic [47:0] src_mac,
    output logic        ip_valid,
    output logic [31:0] src_ip,
    output logic [31:0] dst_ip,
    output logic [7:0]  ip_protocol,
    output logic [15:0] ip_length,
    output logic [1:0]  l4_kind,
    output logic [15:0] l4_sport,
    output logic [15:0] l4_dport
);
    import eth_hp_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_advance;
    logic       out_valid_reg;
    summary_t   out_reg;
    frame_t     upd;
    summary_t   summ;

    // A last byte advances only when the result register can take it
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    eth_hp_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .upd       (upd)
    );

    eth_hp_summary u_summary (
        .frame (upd),
        .summ  (summ)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
            out_reg <= summ;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign ethertype   = out_reg.ethertype;
    assign dst_mac     = out_reg.dst_mac;
    assign src_mac     = out_reg.src_mac;
    assign ip_valid    = out_reg.ip_valid;
    assign src_ip      = out_reg.src_ip;
    assign dst_ip      = out_reg.dst_ip;
    assign ip_protocol = out_reg.ip_protocol;
    assign ip_length   = out_reg.ip_length;
    assign l4_kind     = out_reg.l4_kind;
    assign l4_sport    = out_reg.l4_sport;
    assign l4_dport    = out_reg.l4_dport;

`ifndef ASSERT_OFF
    // A last byte that advances always yields a summary next cycle
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> out_valid_reg)
        else $error("last byte did not produce a summary");

    // A stalled summary blocks a waiting last byte
    a_last_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s1_valid_reg && s1_last_reg) |-> !in_ready)
        else $error("last byte advanced over a stalled summary");

    // L4 kind is only set on an ok frame
    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK) |-> (out_reg.l4_kind == L4_NONE))
        else $error("l4 kind set on a failed frame");

    // Ports are zero unless the frame is tcp or udp
    a_ports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.l4_kind == L4_NONE || out_reg.l4_kind == L4_ICMP))
        |-> (out_reg.l4_sport == 16'd0 && out_reg.l4_dport == 16'd0))
        else $error("ports nonzero without tcp or udp");
`endif

endmodule
